/* src/cst_pkg.sv */
// ============================================================================
// cst_pkg
// Shared types and constants of the counting semaphore table.
// ============================================================================
`default_nettype none

package cst_pkg;

    // Default table sizes, handed to the top level parameters.
    localparam int SEMAPHORES_DEF = 32;
    localparam int THREADS_DEF    = 16;

    // Most result items that one remove command may produce.
    localparam int MAX_RES = 16;

    // Field widths fixed by the command and result formats.
    localparam int CMD_W   = 3;
    localparam int SID_W   = 5;
    localparam int INIT_W  = 15;
    localparam int TID_W   = 4;
    localparam int COUNT_W = 16;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE  = 3'd0,
        CMD_WAIT    = 3'd1,
        CMD_SIGNAL  = 3'd2,
        CMD_REMOVE  = 3'd3,
        CMD_RELEASE = 3'd4
    } t_cmd;

    // One result item as held in the output register.
    typedef struct packed {
        logic             status;
        logic [SID_W-1:0] new_id;
        logic             caller_blocks;
        logic             woken_valid;
        logic [TID_W-1:0] woken_thread;
        logic             last;
    } t_res;

endpackage

`default_nettype wire

/* src/cst_cmd_if.sv */
// ============================================================================
// cst_cmd_if
// Command channel of the semaphore table: valid/ready plus one command item.
// ============================================================================
`default_nettype none

interface cst_cmd_if;

    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [4:0]  sem_id;
    logic [14:0] init_value;
    logic [3:0]  thread_id;

    modport source (
        output valid, command, sem_id, init_value, thread_id,
        input  ready
    );

    modport sink (
        input  valid, command, sem_id, init_value, thread_id,
        output ready
    );

endinterface

`default_nettype wire

/* src/cst_res_if.sv */
// ============================================================================
// cst_res_if
// Result channel of the semaphore table: valid/ready plus one result item.
// ============================================================================
`default_nettype none

interface cst_res_if;

    logic       valid;
    logic       ready;
    logic       status;
    logic [4:0] new_id;
    logic       caller_blocks;
    logic       woken_valid;
    logic [3:0] woken_thread;
    logic       last;

    modport source (
        output valid, status, new_id, caller_blocks, woken_valid, woken_thread, last,
        input  ready
    );

    modport sink (
        input  valid, status, new_id, caller_blocks, woken_valid, woken_thread, last,
        output ready
    );

endinterface

`default_nettype wire

/* src/counting_semaphore_table.sv */
// ============================================================================
// counting_semaphore_table
// Hardware semaphore table with a FIFO wait queue per slot.
// ============================================================================
// The block takes one command item at a time and answers with one result
// item, or with one result item per woken thread for remove. Create, wait,
// release, plain signal and every error go through the synchronous read
// of the slot memory, then a step that modifies and writes it back and
// puts the result into the output register. A signal that wakes a thread
// adds a step, since the head's next pointer is read from the next-waiter
// memory after the head itself arrives. Remove adds one step per woken
// waiter (at most 16), the drain walking the next-waiter chain one entry a
// cycle while the result side does not stall. A new command is accepted in
// the cycle after the last result of the previous one is registered, and
// not before. Stalls on the result side hold the block in place without
// losing an item. In-use, active and queue-nonempty flags sit in flip-flops
// cleared by reset; counts, queue heads, tails and next pointers live in
// memories that need no clearing pass.
// ============================================================================
`default_nettype none

module counting_semaphore_table #(
    parameter int SEMAPHORES = cst_pkg::SEMAPHORES_DEF,
    parameter int THREADS    = cst_pkg::THREADS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cst_cmd_if.sink   i_cmd,
    cst_res_if.source o_res
);

    localparam int SW    = $clog2(SEMAPHORES);
    localparam int TW    = $clog2(THREADS);
    localparam int NW    = $clog2(cst_pkg::MAX_RES);
    localparam int SLOTW = cst_pkg::COUNT_W + 2 * cst_pkg::TID_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_POP  = 3'b100
    } t_state;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state                              r_state,    n_state;
    logic [cst_pkg::CMD_W-1:0]           r_cmd,      n_cmd;
    logic [SW-1:0]                       r_sidx,     n_sidx;
    logic                                r_sid_ok,   n_sid_ok;
    logic [cst_pkg::INIT_W-1:0]          r_init,     n_init;
    logic [cst_pkg::TID_W-1:0]           r_th,       n_th;
    logic                                r_th_ok,    n_th_ok;
    logic signed [cst_pkg::COUNT_W-1:0]  r_count,    n_count;
    logic [cst_pkg::TID_W-1:0]           r_head,     n_head;
    logic [cst_pkg::TID_W-1:0]           r_tail,     n_tail;
    logic                                r_rmv,      n_rmv;
    logic [NW-1:0]                       r_n,        n_n;
    logic [SEMAPHORES-1:0]               r_used,     n_used;
    logic [SEMAPHORES-1:0]               r_active,   n_active;
    logic [SEMAPHORES-1:0]               r_nonempty, n_nonempty;
    cst_pkg::t_res                       r_out,      n_out;
    logic                                r_out_valid;

    // ------------------------------------------------------------------
    // Memories: slot word {count, head, tail} and one next pointer per
    // thread. Both have registered read data.
    // ------------------------------------------------------------------
    logic [SLOTW-1:0]          m_slot [SEMAPHORES];
    logic [SLOTW-1:0]          r_slot_q;
    logic [SW-1:0]             slot_raddr;
    logic                      slot_we;
    logic [SW-1:0]             slot_waddr;
    logic [SLOTW-1:0]          slot_wdata;

    logic [cst_pkg::TID_W-1:0] m_next [THREADS];
    logic [cst_pkg::TID_W-1:0] r_next_q;
    logic [TW-1:0]             next_raddr;
    logic                      next_we;
    logic [TW-1:0]             next_waddr;

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            m_slot[slot_waddr] <= slot_wdata;
        end
        r_slot_q <= m_slot[slot_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            m_next[next_waddr] <= r_th;
        end
        r_next_q <= m_next[next_raddr];
    end

    // ------------------------------------------------------------------
    // Free slot finder for create.
    // ------------------------------------------------------------------
    logic          free_found;
    logic [SW-1:0] free_idx;

    cst_alloc #(
        .SEMAPHORES (SEMAPHORES)
    ) u_alloc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_used  (r_used),
        .o_found (free_found),
        .o_idx   (free_idx)
    );

    // ------------------------------------------------------------------
    // Command sequencer
    // ------------------------------------------------------------------
    logic signed [cst_pkg::COUNT_W-1:0] q_count;
    logic [cst_pkg::TID_W-1:0]          q_head;
    logic [cst_pkg::TID_W-1:0]          q_tail;
    logic signed [cst_pkg::COUNT_W-1:0] cnt_dec;
    logic signed [cst_pkg::COUNT_W-1:0] cnt_inc;
    logic                               ok_id;
    logic                               out_free;
    logic                               emit;
    logic                               empty_after;
    logic                               advance;

    assign q_count = r_slot_q[SLOTW-1 -: cst_pkg::COUNT_W];
    assign q_head  = r_slot_q[2*cst_pkg::TID_W-1 -: cst_pkg::TID_W];
    assign q_tail  = r_slot_q[cst_pkg::TID_W-1:0];

    // Saturating step of the count in either direction.
    assign cnt_dec = (q_count == cst_pkg::COUNT_MIN) ? q_count : q_count - 16'sd1;
    assign cnt_inc = (q_count == cst_pkg::COUNT_MAX) ? q_count : q_count + 16'sd1;

    assign ok_id    = r_sid_ok && r_used[r_sidx];
    assign out_free = !r_out_valid || o_res.ready;

    // The popped thread is the last in its queue when it is the tail, or when
    // its id cannot index the next-pointer memory.
    assign empty_after = (r_head == r_tail) || (32'(r_head) >= THREADS);

    // A remove drain moves on to the next waiter in this cycle.
    assign advance = (r_state == S_POP) && out_free && r_rmv && !empty_after &&
                     (r_n != NW'(cst_pkg::MAX_RES - 1));

    assign slot_raddr = (r_state == S_IDLE) ? SW'(i_cmd.sem_id) : r_sidx;

    // The next-pointer read always targets the head that the following cycle
    // will hold, so the drain runs at one waiter a cycle while the output is free.
    always_comb begin
        if (r_state == S_EXEC) begin
            next_raddr = TW'(q_head);
        end else if (advance) begin
            next_raddr = TW'(r_next_q);
        end else begin
            next_raddr = TW'(r_head);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_sidx     = r_sidx;
        n_sid_ok   = r_sid_ok;
        n_init     = r_init;
        n_th       = r_th;
        n_th_ok    = r_th_ok;
        n_count    = r_count;
        n_head     = r_head;
        n_tail     = r_tail;
        n_rmv      = r_rmv;
        n_n        = r_n;
        n_used     = r_used;
        n_active   = r_active;
        n_nonempty = r_nonempty;
        n_out      = '0;
        n_out.last = 1'b1;
        emit       = 1'b0;
        slot_we    = 1'b0;
        slot_waddr = r_sidx;
        slot_wdata = r_slot_q;
        next_we    = 1'b0;
        next_waddr = TW'(q_tail);

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd    = i_cmd.command;
                    n_sidx   = SW'(i_cmd.sem_id);
                    n_sid_ok = 32'(i_cmd.sem_id) < SEMAPHORES;
                    n_init   = i_cmd.init_value;
                    n_th     = i_cmd.thread_id;
                    n_th_ok  = 32'(i_cmd.thread_id) < THREADS;
                    n_state  = S_EXEC;
                end
            end

            S_EXEC: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    case (r_cmd)
                        cst_pkg::CMD_CREATE: begin
                            if (free_found) begin
                                n_used[free_idx]     = 1'b1;
                                n_active[free_idx]   = 1'b1;
                                n_nonempty[free_idx] = 1'b0;
                                slot_we      = 1'b1;
                                slot_waddr   = free_idx;
                                slot_wdata   = {1'b0, r_init, {(2*cst_pkg::TID_W){1'b0}}};
                                n_out.new_id = cst_pkg::SID_W'(free_idx);
                            end else begin
                                n_out.status = 1'b1;
                            end
                        end

                        cst_pkg::CMD_WAIT: begin
                            if (!ok_id || !r_active[r_sidx] || !r_th_ok) begin
                                n_out.status = 1'b1;
                            end else if (cnt_dec[cst_pkg::COUNT_W-1]) begin
                                // Count went negative: append the caller.
                                slot_we = 1'b1;
                                if (r_nonempty[r_sidx] && (32'(q_tail) < THREADS)) begin
                                    next_we    = 1'b1;
                                    slot_wdata = {cnt_dec, q_head, r_th};
                                end else begin
                                    n_nonempty[r_sidx] = 1'b1;
                                    slot_wdata         = {cnt_dec, r_th, r_th};
                                end
                                n_out.caller_blocks = 1'b1;
                            end else begin
                                slot_we    = 1'b1;
                                slot_wdata = {cnt_dec, q_head, q_tail};
                            end
                        end

                        cst_pkg::CMD_SIGNAL: begin
                            if (!ok_id) begin
                                n_out.status = 1'b1;
                            end else if (cnt_inc[cst_pkg::COUNT_W-1] || (cnt_inc == '0)) begin
                                if (r_nonempty[r_sidx]) begin
                                    // Wake the head; finished once its next pointer is in.
                                    emit    = 1'b0;
                                    n_count = cnt_inc;
                                    n_head  = q_head;
                                    n_tail  = q_tail;
                                    n_rmv   = 1'b0;
                                    n_state = S_POP;
                                end else begin
                                    // Queue already drained by remove.
                                    slot_we      = 1'b1;
                                    slot_wdata   = {cnt_inc, q_head, q_tail};
                                    n_out.status = 1'b1;
                                end
                            end else begin
                                slot_we    = 1'b1;
                                slot_wdata = {cnt_inc, q_head, q_tail};
                            end
                        end

                        cst_pkg::CMD_REMOVE: begin
                            if (!ok_id) begin
                                n_out.status = 1'b1;
                            end else if (r_nonempty[r_sidx]) begin
                                emit    = 1'b0;
                                n_head  = q_head;
                                n_tail  = q_tail;
                                n_rmv   = 1'b1;
                                n_n     = '0;
                                n_state = S_POP;
                            end else begin
                                n_active[r_sidx] = 1'b0;
                            end
                        end

                        cst_pkg::CMD_RELEASE: begin
                            if (!ok_id) begin
                                n_out.status = 1'b1;
                            end else begin
                                n_used[r_sidx]   = 1'b0;
                                n_active[r_sidx] = 1'b0;
                            end
                        end

                        default: begin
                            n_out.status = 1'b1;
                        end
                    endcase
                end
            end

            S_POP: begin
                if (out_free) begin
                    emit               = 1'b1;
                    n_out.woken_valid  = 1'b1;
                    n_out.woken_thread = r_head;
                    if (!r_rmv) begin
                        slot_we    = 1'b1;
                        slot_wdata = {r_count, (empty_after ? r_head : r_next_q), r_tail};
                        n_nonempty[r_sidx] = !empty_after;
                        n_state            = S_IDLE;
                    end else if (advance) begin
                        n_out.last = 1'b0;
                        n_head     = r_next_q;
                        n_n        = r_n + NW'(1);
                    end else begin
                        // Queue empty or result limit reached: the rest is dropped.
                        n_nonempty[r_sidx] = 1'b0;
                        n_active[r_sidx]   = 1'b0;
                        n_state            = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_active    <= '0;
            r_nonempty  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_used     <= n_used;
            r_active   <= n_active;
            r_nonempty <= n_nonempty;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_cmd    <= n_cmd;
        r_sidx   <= n_sidx;
        r_sid_ok <= n_sid_ok;
        r_init   <= n_init;
        r_th     <= n_th;
        r_th_ok  <= n_th_ok;
        r_count  <= n_count;
        r_head   <= n_head;
        r_tail   <= n_tail;
        r_rmv    <= n_rmv;
        r_n      <= n_n;
        if (emit) begin
            r_out <= n_out;
        end
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign i_cmd.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out.status;
    assign o_res.new_id       = r_out.new_id;
    assign o_res.caller_blocks = r_out.caller_blocks;
    assign o_res.woken_valid  = r_out.woken_valid;
    assign o_res.woken_thread = r_out.woken_thread;
    assign o_res.last         = r_out.last;

`ifndef SYNTHESIS
    // The final result of a command returns the sequencer to idle.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && n_out.last) |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle after a final result");

    // An active slot is always an allocated slot.
    a_active_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active & ~r_used) == '0)
        else $error("active slot without its in-use flag");

    // A wakeup is only ever worked on for an allocated slot with a queue.
    a_pop_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> (r_used[r_sidx] && r_nonempty[r_sidx]))
        else $error("wakeup on a slot without a queue");

    // A new result never appears straight out of idle.
    a_no_idle_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (r_state != S_IDLE))
        else $error("result emitted while idle");
`endif

endmodule

`default_nettype wire

/* src/cst_alloc.sv */
// ============================================================================
// cst_alloc
// Free slot finder: registers the lowest slot whose in-use bit is clear.
// ============================================================================
`default_nettype none

module cst_alloc #(
    parameter int SEMAPHORES = cst_pkg::SEMAPHORES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [SEMAPHORES-1:0]         i_used,
    output logic                               o_found,
    output logic [$clog2(SEMAPHORES)-1:0]      o_idx
);

    localparam int SW = $clog2(SEMAPHORES);

    logic          n_found;
    logic [SW-1:0] n_idx;
    logic          r_found;
    logic [SW-1:0] r_idx;

    // Scan from the top down so that the lowest free slot wins.
    always_comb begin
        n_found = 1'b0;
        n_idx   = '0;
        for (int i = SEMAPHORES - 1; i >= 0; i--) begin
            if (!i_used[i]) begin
                n_found = 1'b1;
                n_idx   = SW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else begin
            r_found <= n_found;
        end
        r_idx <= n_idx;
    end

    assign o_found = r_found;
    assign o_idx   = r_idx;

endmodule

`default_nettype wire
